// ===== rtl/core/rle_pkg.sv =====
// Shared types, register indexes and palette for the RGB LED effect controller.
package rle_pkg;

  localparam int CFG_W = 10;
  localparam int TICK_W = 10;

  localparam logic [1:0] CFG_FADE_STEP_TICKS   = 2'd0;
  localparam logic [1:0] CFG_BLINK_HALF_TICKS  = 2'd1;
  localparam logic [1:0] CFG_BLINK_COLOR_INDEX = 2'd2;

  typedef enum logic [1:0] {
    MODE_RAINBOW = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_STEADY  = 2'd2
  } mode_t;

  typedef struct packed {
    logic  refresh;
    mode_t mode;
  } ctl_t;

  localparam logic [23:0] BASE_PALETTE [8] = '{
    24'h00FF00, 24'hFF0000, 24'hFF7F00, 24'hFFFF00,
    24'h9400D3, 24'h0000FF, 24'h4B0082, 24'hFFFFFF
  };

  function automatic logic [23:0] palette_entry(input logic [3:0] idx);
    return BASE_PALETTE[idx[2:0]];
  endfunction

endpackage

// ===== rtl/core/rle_ifs.sv =====
// Request channels of the RGB LED effect controller: tick input and color result.
interface rle_in_if;
  logic valid;
  logic ready;
  logic button_press;

  modport source (output valid, output button_press, input ready);
  modport sink (input valid, input button_press, output ready);
endinterface

interface rle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] mode;
  logic       refresh;

  modport source (output valid, output red, output green, output blue,
                  output mode, output refresh, input ready);
  modport sink (input valid, input red, input green, input blue,
                input mode, input refresh, output ready);
endinterface

// ===== rtl/core/rgb_led_effect_controller.sv =====
// RGB LED effect controller top level: configuration registers and input stage.
// Pipeline of three register stages: input, control, result.
// A request passes the input, control and result registers. Throughput: one
// request per cycle unless stalled; the control-stage counter update is the loop.
// Synchronous active-low reset: steady mode, LED off, counters cleared,
// registers at 10, 200 and 0; no clearing pass.
module rgb_led_effect_controller #(
  parameter int PALETTE_SIZE = 8,
  parameter int FADE_STEPS   = 100
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rle_in_if.sink                    in_chan,
  rle_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [rle_pkg::CFG_W-1:0] cfg_wdata
);
  import rle_pkg::*;

  localparam int PROD_W = $clog2(FADE_STEPS) + 8;

  logic [CFG_W-1:0] fade_ticks_r, blink_ticks_r;
  logic [2:0]       blink_idx_r;
  logic             s_valid_r, s_press_r, s_ready;
  logic             m_valid, m_ready;
  ctl_t             m_ctl;
  logic [2:0][7:0]  m_base;
  logic [2:0]       m_neg;
  logic [2:0][PROD_W-1:0] m_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_ticks_r  <= CFG_W'(10);
      blink_ticks_r <= CFG_W'(200);
      blink_idx_r   <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FADE_STEP_TICKS:   fade_ticks_r  <= cfg_wdata;
        CFG_BLINK_HALF_TICKS:  blink_ticks_r <= cfg_wdata;
        CFG_BLINK_COLOR_INDEX: blink_idx_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = !s_valid_r || s_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) s_press_r <= in_chan.button_press;
  end

  rle_ctrl #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .FADE_STEPS   (FADE_STEPS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_valid     (s_valid_r),
    .s_press     (s_press_r),
    .s_ready     (s_ready),
    .fade_ticks  (fade_ticks_r),
    .blink_ticks (blink_ticks_r),
    .blink_idx   (blink_idx_r),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_ctl       (m_ctl),
    .m_base      (m_base),
    .m_neg       (m_neg),
    .m_prod      (m_prod)
  );

  rle_blend #(
    .FADE_STEPS (FADE_STEPS)
  ) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_ctl    (m_ctl),
    .m_base   (m_base),
    .m_neg    (m_neg),
    .m_prod   (m_prod),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/core/rle_ctrl.sv =====
// Mode, fade and blink sequencing; picks the next color and forms blend products.
module rle_ctrl #(
  parameter int PALETTE_SIZE = 8,
  parameter int FADE_STEPS   = 100
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   s_valid,
  input  logic                                   s_press,
  output logic                                   s_ready,
  input  logic [rle_pkg::CFG_W-1:0]              fade_ticks,
  input  logic [rle_pkg::CFG_W-1:0]              blink_ticks,
  input  logic [2:0]                             blink_idx,
  output logic                                   m_valid,
  input  logic                                   m_ready,
  output rle_pkg::ctl_t                          m_ctl,
  output logic [2:0][7:0]                        m_base,
  output logic [2:0]                             m_neg,
  output logic [2:0][$clog2(FADE_STEPS)+7:0]     m_prod
);
  import rle_pkg::*;

  localparam int POS_W  = $clog2(PALETTE_SIZE);
  localparam int STEP_W = $clog2(FADE_STEPS);
  localparam int PROD_W = STEP_W + 8;

  mode_t               mode_r, mode_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt, pos2;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt, tick_inc, fade_len, blink_len;
  logic                phase_r, phase_nxt;
  logic [STEP_W:0]     step_inc;
  logic [POS_W-1:0]    pos_inc;
  logic                take, load, rainbow;
  logic [4:0]          bidx;
  logic [2:0][7:0]     c1, c2, base, bcol;
  logic [2:0][7:0]     mag;
  logic [2:0]          neg;
  logic [2:0][PROD_W-1:0] prod;
  logic                m_valid_r;
  ctl_t                m_ctl_r;
  logic [2:0][7:0]     m_base_r;
  logic [2:0]          m_neg_r;
  logic [2:0][PROD_W-1:0] m_prod_r;

  assign s_ready = !m_valid_r || m_ready;
  assign take    = s_valid && s_ready;

  assign tick_inc  = tick_r + TICK_W'(1);
  assign fade_len  = (fade_ticks == '0) ? TICK_W'(1) : fade_ticks;
  assign blink_len = (blink_ticks == '0) ? TICK_W'(1) : blink_ticks;
  assign step_inc  = {1'b0, step_r} + (STEP_W+1)'(1);
  assign pos_inc   = (pos_r == POS_W'(PALETTE_SIZE - 1)) ? '0 : pos_r + POS_W'(1);

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    load      = 1'b0;
    rainbow   = 1'b0;
    if (take) begin
      if (s_press) begin
        tick_nxt = '0;
        unique case (mode_r)
          MODE_RAINBOW: mode_nxt = MODE_BLINK;
          MODE_BLINK:   mode_nxt = MODE_STEADY;
          default:      mode_nxt = MODE_RAINBOW;
        endcase
        if (mode_nxt == MODE_RAINBOW) begin
          step_nxt = '0;
          rainbow  = 1'b1;
          load     = 1'b1;
        end else if (mode_nxt == MODE_BLINK) begin
          phase_nxt = 1'b0;
          load      = 1'b1;
        end
      end else begin
        unique case (mode_r)
          MODE_RAINBOW: begin
            tick_nxt = tick_inc;
            if (tick_inc >= fade_len) begin
              tick_nxt = '0;
              if (step_inc >= (STEP_W+1)'(FADE_STEPS)) begin
                step_nxt = '0;
                pos_nxt  = pos_inc;
              end else begin
                step_nxt = step_inc[STEP_W-1:0];
              end
              rainbow = 1'b1;
              load    = 1'b1;
            end
          end
          MODE_BLINK: begin
            tick_nxt = tick_inc;
            if (tick_inc >= blink_len) begin
              tick_nxt  = '0;
              phase_nxt = !phase_r;
              load      = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // color source and blend products
  always_comb begin
    bidx = {2'b00, blink_idx};
    for (int j = 0; j < 4; j++) begin
      if (bidx >= 5'(PALETTE_SIZE)) bidx = bidx - 5'(PALETTE_SIZE);
    end
    bcol = palette_entry(bidx[3:0]);
    pos2 = (pos_nxt == POS_W'(PALETTE_SIZE - 1)) ? '0 : pos_nxt + POS_W'(1);
    c1 = palette_entry(4'(pos_nxt));
    c2 = palette_entry(4'(pos2));
    for (int j = 0; j < 3; j++) begin
      neg[j] = 1'b0;
      mag[j] = '0;
      if (rainbow) begin
        base[j] = c1[j];
        neg[j]  = c2[j] < c1[j];
        mag[j]  = neg[j] ? c1[j] - c2[j] : c2[j] - c1[j];
      end else if (phase_nxt) begin
        base[j] = bcol[j];
      end else begin
        base[j] = '0;
      end
      prod[j] = PROD_W'(step_nxt) * PROD_W'(mag[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_STEADY;
      pos_r     <= '0;
      step_r    <= '0;
      tick_r    <= '0;
      phase_r   <= 1'b0;
      m_valid_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      step_r  <= step_nxt;
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      if (s_ready) m_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_ctl_r.refresh <= load;
      m_ctl_r.mode    <= mode_nxt;
      m_base_r        <= base;
      m_neg_r         <= neg;
      m_prod_r        <= prod;
    end
  end

  assign m_valid = m_valid_r;
  assign m_ctl   = m_ctl_r;
  assign m_base  = m_base_r;
  assign m_neg   = m_neg_r;
  assign m_prod  = m_prod_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(step_r) < FADE_STEPS)
    else $error("fade step out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < PALETTE_SIZE)
    else $error("palette position out of range");

  a_press_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s_press) |=>
      (m_valid_r && (m_ctl_r.refresh == (m_ctl_r.mode != MODE_STEADY))))
    else $error("press refresh mismatch");

endmodule

// ===== rtl/core/rle_blend.sv =====
// Divides blend products by the step count and holds the shown color and result.
module rle_blend #(
  parameter int FADE_STEPS = 100
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               m_valid,
  output logic                               m_ready,
  input  rle_pkg::ctl_t                      m_ctl,
  input  logic [2:0][7:0]                    m_base,
  input  logic [2:0]                         m_neg,
  input  logic [2:0][$clog2(FADE_STEPS)+7:0] m_prod,
  rle_out_if.source                          out_chan
);
  import rle_pkg::*;

  localparam int STEP_W = $clog2(FADE_STEPS);
  localparam int PROD_W = STEP_W + 8;
  localparam int SH     = PROD_W + STEP_W;
  localparam int FULL_W = PROD_W + SH;
  localparam logic [SH-1:0] RECIP =
    SH'(((64'd1 << SH) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS));

  logic [2:0][FULL_W-1:0] full;
  logic [2:0][7:0]        quo, mix;
  logic [2:0][7:0]        shown_r;
  logic                   out_valid_r, refresh_r;
  mode_t                  mode_r;
  logic                   take;

  assign m_ready = !out_valid_r || out_chan.ready;
  assign take    = m_valid && m_ready;

  // exact floor division by reciprocal multiply
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      full[j] = FULL_W'(m_prod[j]) * FULL_W'(RECIP);
      quo[j]  = full[j][SH +: 8];
      mix[j]  = m_neg[j] ? m_base[j] - quo[j] : m_base[j] + quo[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      shown_r     <= '0;
    end else begin
      if (m_ready) out_valid_r <= m_valid;
      if (take && m_ctl.refresh) shown_r <= mix;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      refresh_r <= m_ctl.refresh;
      mode_r    <= m_ctl.mode;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.red     = shown_r[2];
  assign out_chan.green   = shown_r[1];
  assign out_chan.blue    = shown_r[0];
  assign out_chan.mode    = mode_r;
  assign out_chan.refresh = refresh_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !m_ctl.refresh) |=> $stable(shown_r))
    else $error("held color changed");

  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("taken request not presented");

  a_plain_load: assert property (@(posedge clk) disable iff (!rst_n)
    (take && m_ctl.refresh && (m_prod == '0)) |=> (shown_r == $past(m_base)))
    else $error("unblended color mismatch");

endmodule

// ===== dv/rgb_led_effect_controller_tb.sv =====
// Self-checking testbench for the RGB LED effect controller: tick requests in, colors checked.
module rgb_led_effect_controller_tb;
  import rle_pkg::*;

  localparam int NUM_COLORS = 8;
  localparam int STEPS      = 100;
  localparam int LIMIT      = 200000;
  localparam int SETTLE     = 20;
  localparam int SPLIT_A    = 460;
  localparam int SPLIT_B    = 920;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    mode_t      mode;
    logic       refresh;
  } led_state_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_FADE_STEP_TICKS;
  logic [CFG_W-1:0] cfg_wdata = '0;

  rle_in_if  in_chan ();
  rle_out_if out_chan ();

  rgb_led_effect_controller #(
    .PALETTE_SIZE(NUM_COLORS),
    .FADE_STEPS  (STEPS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Effect state mirror and register copies.
  int          fade_ticks_cfg = 10;
  int          blink_ticks_cfg = 200;
  int          blink_idx_cfg = 0;
  mode_t       cur_mode = MODE_STEADY;
  int          pal_pos = 0;
  int          step_idx = 0;
  int          tick_cnt = 0;
  bit          blink_on = 1'b0;
  logic [23:0] led_color = '0;

  led_state_t led_expect_q [$];
  bit         tick_q [$];
  mode_t      gen_mode = MODE_STEADY;

  int errors = 0;
  int in_count = 0;
  int out_count = 0;
  int refresh_count = 0;
  int setting_count = 0;
  int cycle_count = 0;

  function automatic mode_t next_mode(mode_t m);
    case (m)
      MODE_RAINBOW: return MODE_BLINK;
      MODE_BLINK:   return MODE_STEADY;
      default:      return MODE_RAINBOW;
    endcase
  endfunction

  function automatic logic [23:0] palette_color(int i);
    return BASE_PALETTE[(i % NUM_COLORS) & 7];
  endfunction

  function automatic logic [7:0] mix_channel(int a, int b, int k);
    int p;
    p = k * (b - a) / STEPS;
    return 8'((a + p) & 255);
  endfunction

  function automatic logic [23:0] rainbow_mix();
    logic [23:0] c1;
    logic [23:0] c2;
    c1 = palette_color(pal_pos);
    c2 = palette_color((pal_pos + 1) % NUM_COLORS);
    return {mix_channel(c1[23:16], c2[23:16], step_idx),
            mix_channel(c1[15:8], c2[15:8], step_idx),
            mix_channel(c1[7:0], c2[7:0], step_idx)};
  endfunction

  function automatic led_state_t advance_tick(bit press);
    led_state_t res;
    int         period;
    bit         fresh;
    fresh = 1'b0;
    if (press) begin
      cur_mode = next_mode(cur_mode);
      tick_cnt = 0;
      if (cur_mode == MODE_RAINBOW) begin
        step_idx = 0;
        led_color = rainbow_mix();
        fresh = 1'b1;
      end else if (cur_mode == MODE_BLINK) begin
        blink_on = 1'b0;
        led_color = '0;
        fresh = 1'b1;
      end
    end else if (cur_mode == MODE_RAINBOW) begin
      period = (fade_ticks_cfg != 0) ? fade_ticks_cfg : 1;
      tick_cnt = (tick_cnt + 1) & 'h3FF;
      if (tick_cnt >= period) begin
        tick_cnt = 0;
        step_idx++;
        if (step_idx >= STEPS) begin
          step_idx = 0;
          pal_pos = (pal_pos + 1) % NUM_COLORS;
        end
        led_color = rainbow_mix();
        fresh = 1'b1;
      end
    end else if (cur_mode == MODE_BLINK) begin
      period = (blink_ticks_cfg != 0) ? blink_ticks_cfg : 1;
      tick_cnt = (tick_cnt + 1) & 'h3FF;
      if (tick_cnt >= period) begin
        tick_cnt = 0;
        blink_on = ~blink_on;
        led_color = blink_on ? palette_color(blink_idx_cfg) : 24'h000000;
        fresh = 1'b1;
      end
    end
    res.red = led_color[23:16];
    res.green = led_color[15:8];
    res.blue = led_color[7:0];
    res.mode = cur_mode;
    res.refresh = fresh;
    return res;
  endfunction

  function automatic bit idle_roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Tick request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.button_press <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        led_expect_q.push_back(advance_tick(in_chan.button_press));
        in_count++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (tick_q.size() > 0 &&
            !idle_roll(in_count < SPLIT_A ? 26 : in_count < SPLIT_B ? 64 : 0)) begin
          in_chan.valid <= 1'b1;
          in_chan.button_press <= tick_q.pop_front();
        end else begin
          in_chan.valid <= 1'b0;
          in_chan.button_press <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // Color result monitor.
  always @(posedge clk) begin : monitor
    led_state_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (led_expect_q.size() == 0) begin
          $error("color result with no tick request pending");
          errors++;
        end else begin
          want = led_expect_q.pop_front();
          check_field("red", want.red, out_chan.red);
          check_field("green", want.green, out_chan.green);
          check_field("blue", want.blue, out_chan.blue);
          check_field("mode", want.mode, out_chan.mode);
          check_field("refresh", want.refresh, out_chan.refresh);
          if (want.refresh) refresh_count++;
        end
        out_count++;
      end
      out_chan.ready <= !idle_roll(out_count < SPLIT_A ? 64 : out_count < SPLIT_B ? 26 : 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("rgb_led_effect_controller_tb: FAIL");
      $finish;
    end
  end

  task automatic push_tick(bit press);
    tick_q.push_back(press);
    if (press) gen_mode = next_mode(gen_mode);
  endtask

  task automatic press_until(mode_t target);
    while (gen_mode != target) push_tick(1'b1);
  endtask

  task automatic push_quiet(int n);
    repeat (n) push_tick(1'b0);
  endtask

  // Mode runs of random length, with short bursts of random presses mixed in.
  task automatic push_runs(int n_items, int run_max);
    int made;
    int len;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 4);
        repeat (len) push_tick(1'($urandom_range(0, 1)));
        made += len;
      end else begin
        push_tick(1'b1);
        len = $urandom_range(0, gen_mode == MODE_STEADY ? run_max / 4 : run_max);
        push_quiet(len);
        made += 1 + len;
      end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    case (idx)
      CFG_FADE_STEP_TICKS:   fade_ticks_cfg = value & 'h3FF;
      CFG_BLINK_HALF_TICKS:  blink_ticks_cfg = value & 'h3FF;
      CFG_BLINK_COLOR_INDEX: blink_idx_cfg = value & 7;
      default: ;
    endcase
  endtask

  task automatic set_regs(int fade, int blink, int color);
    write_reg(CFG_FADE_STEP_TICKS, fade);
    write_reg(CFG_BLINK_HALF_TICKS, blink);
    write_reg(CFG_BLINK_COLOR_INDEX, color);
    @(posedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  task automatic drain();
    @(posedge clk);
    while (tick_q.size() != 0 || in_chan.valid || led_expect_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    bit directed_seq [24] = '{0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1, 0,
                              0, 1, 1, 1, 1, 1, 0, 1, 0, 1, 0, 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Zero periods act as one tick: every quiet tick in rainbow or blink mode refreshes.
    set_regs(0, 0, 7);
    foreach (directed_seq[i]) push_tick(directed_seq[i]);
    drain();

    // Single-tick steps: a long rainbow run wraps the whole palette.
    set_regs(1, 1, 3);
    press_until(MODE_RAINBOW);
    push_quiet(820);
    push_runs(60, 20);
    drain();

    set_regs(1023, 1023, 0);
    push_runs(150, 60);
    drain();

    set_regs($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(0, 7));
    push_runs(320, 40);
    drain();

    repeat (SETTLE) @(posedge clk);
    $display("Checked %0d tick requests against %0d color results, %0d with refresh,",
             in_count, out_count, refresh_count);
    $display("over %0d register settings including zero and full-scale periods.",
             setting_count);
    if (errors == 0 && led_expect_q.size() == 0) begin
      $display("rgb_led_effect_controller_tb: PASS");
    end else begin
      $display("rgb_led_effect_controller_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== rgb_led_effect_controller.f =====
rtl/core/rle_pkg.sv
rtl/core/rle_ifs.sv
rtl/core/rle_ctrl.sv
rtl/core/rle_blend.sv
rtl/core/rgb_led_effect_controller.sv
dv/rgb_led_effect_controller_tb.sv
